// ===== hw/rtl/spca_pkg.sv =====
// spca_pkg: shared types and constants of the projected curvature accumulator
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
package spca_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic signed [33:0] KEEP_FLOOR = -34'sd10738;
    localparam logic [16:0] UNIT_Q16 = 17'd65536;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // one classified word handed from the front to the back
    typedef struct packed {
        logic             is_start;
        logic             keep;
        logic             last;
        logic [2:0][24:0] d;    // sample minus query point, signed
        logic [2:0][15:0] n;    // normal, signed (used by start words)
    } t_entry;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_SQ   = 11'b00000000010,
        ST_NORM = 11'b00000000100,
        ST_ROOT = 11'b00000001000,
        ST_DSET = 11'b00000010000,
        ST_DIV  = 11'b00000100000,
        ST_ACC  = 11'b00001000000,
        ST_DOT  = 11'b00010000000,
        ST_FSET = 11'b00100000000,
        ST_EMIT = 11'b01000000000,
        ST_SPARE = 11'b10000000000
    } t_state;

    function automatic logic [24:0] mag25(input logic [24:0] v);
        mag25 = v[24] ? (25'd0 - v) : v;
    endfunction

endpackage

// ===== hw/rtl/spca_front.sv =====
// spca_front: accepts words, holds the query, classifies samples
// depends on spca_pkg
`timescale 1ns / 1ps
module spca_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_full,
    input  logic                 i_command,
    input  logic signed [23:0]   i_pos_x,
    input  logic signed [23:0]   i_pos_y,
    input  logic signed [23:0]   i_pos_z,
    input  logic signed [15:0]   i_nrm_x,
    input  logic signed [15:0]   i_nrm_y,
    input  logic signed [15:0]   i_nrm_z,
    input  logic                 i_last,
    output logic                 o_push,
    output spca_pkg::t_entry     o_entry
);

    logic signed [23:0] r_qp [3];
    logic signed [15:0] r_qn [3];
    logic signed [23:0] w_p [3];
    logic signed [15:0] w_n [3];
    logic signed [33:0] w_dot;

    assign w_p[0] = i_pos_x;
    assign w_p[1] = i_pos_y;
    assign w_p[2] = i_pos_z;
    assign w_n[0] = i_nrm_x;
    assign w_n[1] = i_nrm_y;
    assign w_n[2] = i_nrm_z;

    assign o_push = i_valid && !i_full;

    // visibility dot of sample normal and query normal, exact
    assign w_dot = 34'(w_n[0] * r_qn[0]) + 34'(w_n[1] * r_qn[1]) + 34'(w_n[2] * r_qn[2]);

    always_comb begin
        o_entry.is_start = (i_command == spca_pkg::CMD_START);
        o_entry.keep     = (w_dot > spca_pkg::KEEP_FLOOR);
        o_entry.last     = i_last;
        for (int i = 0; i < 3; i++) begin
            o_entry.d[i] = 25'(25'(w_p[i]) - 25'(r_qp[i]));
            o_entry.n[i] = w_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_qp[i] <= '0;
                r_qn[i] <= '0;
            end
        end else if (o_push && i_command == spca_pkg::CMD_START) begin
            for (int i = 0; i < 3; i++) begin
                r_qp[i] <= w_p[i];
                r_qn[i] <= w_n[i];
            end
        end
    end

endmodule

// ===== hw/rtl/spca_queue.sv =====
// spca_queue: short fifo between the front and the back
// depends on spca_pkg
`timescale 1ns / 1ps
module spca_queue #(
    parameter int P_DEPTH = spca_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spca_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output spca_pkg::t_entry o_entry
);

    localparam int AW = $clog2(P_DEPTH);

    spca_pkg::t_entry r_mem [P_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(P_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
            end
            r_cnt <= (AW+1)'(r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop));
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(P_DEPTH)) else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/spca_back.sv =====
// spca_back: sequencer that normalizes offsets, accumulates and divides
// depends on spca_pkg
`timescale 1ns / 1ps
module spca_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  spca_pkg::t_entry     i_entry,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic signed [17:0]   o_curvature,
    output logic [15:0]          o_kept_count
);

    spca_pkg::t_state r_state;
    spca_pkg::t_entry r_ent;
    logic signed [15:0] r_qn [3];
    logic signed [31:0] r_sum [3];
    logic signed [17:0] r_u [3];
    logic [15:0] r_cnt;
    logic [1:0]  r_idx;
    logic [63:0] r_len;
    logic [5:0]  r_s;
    logic [63:0] r_x;
    logic [63:0] r_r;
    logic [63:0] r_b;
    logic [51:0] r_num;
    logic [47:0] r_dv;
    logic [16:0] r_q;
    logic [4:0]  r_qb;
    logic        r_fin;
    logic signed [49:0] r_dot;
    logic signed [17:0] r_res;
    logic        r_ov;

    logic [24:0] w_mag;
    logic        w_ge;
    logic [16:0] w_q;
    logic [16:0] w_qc;
    logic [63:0] w_rb;
    logic [49:0] w_m;
    logic [50:0] w_n;
    logic [30:0] w_den;
    logic [70:0] w_num;
    logic        w_slot;
    logic        w_emit;

    assign w_mag = spca_pkg::mag25(r_ent.d[r_idx]);
    assign w_ge  = (r_num >= {4'd0, r_dv});
    assign w_q   = r_q | (w_ge ? (17'd1 << r_qb) : 17'd0);
    assign w_qc  = (w_q > spca_pkg::UNIT_Q16) ? spca_pkg::UNIT_Q16 : w_q;
    assign w_rb  = r_r + r_b;
    assign w_m   = r_dot[49] ? 50'(-r_dot) : 50'(r_dot);
    assign w_den = {r_cnt, 15'd0};
    assign w_n   = 51'(w_m) + 51'({r_cnt, 14'd0});
    assign w_num = (71'(w_mag) << (16 + 32'(r_s[5:1])));
    assign w_slot = !r_ov || !i_stall;
    assign w_emit = (r_state == spca_pkg::ST_EMIT) && w_slot;
    assign o_pop = (r_state == spca_pkg::ST_IDLE) && !i_empty;

    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spca_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_qn[i]  <= '0;
                r_sum[i] <= '0;
            end
        end else begin
            // a new result replaces the taken one in the same cycle
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                spca_pkg::ST_IDLE: begin
                    if (!i_empty) begin
                        r_ent <= i_entry;
                        r_idx <= '0;
                        r_len <= '0;
                        r_dot <= '0;
                        if (i_entry.is_start) begin
                            for (int i = 0; i < 3; i++) begin
                                r_qn[i]  <= $signed(i_entry.n[i]);
                                r_sum[i] <= '0;
                            end
                            r_cnt   <= '0;
                            r_state <= i_entry.last ? spca_pkg::ST_FSET : spca_pkg::ST_IDLE;
                        end else if (i_entry.keep && r_cnt != spca_pkg::COUNT_MAX) begin
                            r_state <= spca_pkg::ST_SQ;
                        end else begin
                            r_state <= i_entry.last ? spca_pkg::ST_DOT : spca_pkg::ST_IDLE;
                        end
                    end
                end
                spca_pkg::ST_SQ: begin
                    r_len <= r_len + 64'(w_mag * w_mag);
                    r_idx <= 2'(r_idx + 1'b1);
                    if (r_idx == 2'd2) begin
                        r_s     <= '0;
                        r_state <= spca_pkg::ST_NORM;
                    end
                end
                spca_pkg::ST_NORM: begin
                    if (r_len == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_u[i] <= '0;
                        end
                        r_state <= spca_pkg::ST_ACC;
                    end else if (r_s < 6'd60 && r_len[63:60] == 4'd0) begin
                        r_len <= r_len << 2;
                        r_s   <= 6'(r_s + 6'd2);
                    end else begin
                        r_x     <= r_len;
                        r_r     <= '0;
                        r_b     <= 64'd1 << 62;
                        r_state <= spca_pkg::ST_ROOT;
                    end
                end
                spca_pkg::ST_ROOT: begin
                    if (r_x >= w_rb) begin
                        r_x <= r_x - w_rb;
                        r_r <= (r_r >> 1) + r_b;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_b <= r_b >> 2;
                    if (r_b == 64'd1) begin
                        r_idx   <= '0;
                        r_state <= spca_pkg::ST_DSET;
                    end
                end
                spca_pkg::ST_DSET: begin
                    r_num   <= 52'(w_num) + 52'(r_r[31:1]);
                    r_dv    <= {r_r[31:0], 16'd0};
                    r_q     <= '0;
                    r_qb    <= 5'd16;
                    r_fin   <= 1'b0;
                    r_state <= spca_pkg::ST_DIV;
                end
                spca_pkg::ST_DIV: begin
                    if (w_ge) begin
                        r_num <= r_num - {4'd0, r_dv};
                    end
                    r_dv <= r_dv >> 1;
                    r_q  <= w_q;
                    r_qb <= 5'(r_qb - 1'b1);
                    if (r_qb == '0) begin
                        if (r_fin) begin
                            r_res   <= (r_dot > 0) ? -$signed({1'b0, w_qc}) : $signed({1'b0, w_qc});
                            r_state <= spca_pkg::ST_EMIT;
                        end else begin
                            r_u[r_idx] <= r_ent.d[r_idx][24] ? -$signed({1'b0, w_qc})
                                                             : $signed({1'b0, w_qc});
                            if (r_idx == 2'd2) begin
                                r_state <= spca_pkg::ST_ACC;
                            end else begin
                                r_idx   <= 2'(r_idx + 1'b1);
                                r_state <= spca_pkg::ST_DSET;
                            end
                        end
                    end
                end
                spca_pkg::ST_ACC: begin
                    // saturating add into the signed 32-bit sums
                    for (int i = 0; i < 3; i++) begin
                        if (33'(r_sum[i]) + 33'(r_u[i]) > 33'sh07FFFFFFF) begin
                            r_sum[i] <= 32'sh7FFFFFFF;
                        end else if (33'(r_sum[i]) + 33'(r_u[i]) < -33'sh080000000) begin
                            r_sum[i] <= 32'sh80000000;
                        end else begin
                            r_sum[i] <= 32'(33'(r_sum[i]) + 33'(r_u[i]));
                        end
                    end
                    r_cnt   <= 16'(r_cnt + 1'b1);
                    r_idx   <= '0;
                    r_dot   <= '0;
                    r_state <= r_ent.last ? spca_pkg::ST_DOT : spca_pkg::ST_IDLE;
                end
                spca_pkg::ST_DOT: begin
                    r_dot <= r_dot + 50'(r_sum[r_idx] * r_qn[r_idx]);
                    r_idx <= 2'(r_idx + 1'b1);
                    if (r_idx == 2'd2) begin
                        r_state <= spca_pkg::ST_FSET;
                    end
                end
                spca_pkg::ST_FSET: begin
                    if (r_cnt == '0) begin
                        r_res   <= '0;
                        r_state <= spca_pkg::ST_EMIT;
                    end else if (w_n >= 51'({w_den, 17'd0})) begin
                        r_res   <= (r_dot > 0) ? -18'sd65536 : 18'sd65536;
                        r_state <= spca_pkg::ST_EMIT;
                    end else begin
                        r_num   <= 52'(w_n);
                        r_dv    <= 48'({w_den, 16'd0});
                        r_q     <= '0;
                        r_qb    <= 5'd16;
                        r_fin   <= 1'b1;
                        r_state <= spca_pkg::ST_DIV;
                    end
                end
                spca_pkg::ST_EMIT: begin
                    if (w_slot) begin
                        o_curvature  <= r_res;
                        o_kept_count <= r_cnt;
                        r_state      <= spca_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= spca_pkg::ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state) == spca_pkg::ST_EMIT)
        else $error("result shown outside emit");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spca_pkg::ST_DIV |-> r_qb <= 5'd16)
        else $error("quotient bit out of range");
`endif

endmodule

// ===== hw/rtl/surface_projected_curvature_accumulator.sv =====
// surface_projected_curvature_accumulator: top level, front, queue and back
// depends on spca_pkg, spca_front, spca_queue, spca_back
`timescale 1ns / 1ps
// A start word (command 0) loads the query point and unit normal and clears
// the sums; sample words (command 1) are tested for visibility in the front
// as they arrive and queued; the back normalizes each kept offset (squared
// length from the three components, shift search, bit-serial square root
// of 32 steps, three 17-step divisions) and adds it to the sums. A word
// with last set yields one result: curvature and kept count. For a kept
// sample with a nonzero offset the time in the back is dominated by the
// root and the divisions and varies with the shift search; a kept zero
// offset skips the shift search, root and divisions, and a result adds the
// final dot product and, where needed, a division. The input is taken
// whenever the queue has room, the output sits in its own register.
module surface_projected_curvature_accumulator #(
    parameter int P_QUEUE_DEPTH = spca_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_command,
    input  logic signed [23:0]   i_pos_x,
    input  logic signed [23:0]   i_pos_y,
    input  logic signed [23:0]   i_pos_z,
    input  logic signed [15:0]   i_nrm_x,
    input  logic signed [15:0]   i_nrm_y,
    input  logic signed [15:0]   i_nrm_z,
    input  logic                 i_last,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [17:0]   o_curvature,
    output logic [15:0]          o_kept_count
);

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    spca_pkg::t_entry w_in_entry;
    spca_pkg::t_entry w_out_entry;

    // input stalls only when the queue is full
    assign o_stall = w_full;

    spca_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_full    (w_full),
        .i_command (i_command),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_nrm_x   (i_nrm_x),
        .i_nrm_y   (i_nrm_y),
        .i_nrm_z   (i_nrm_z),
        .i_last    (i_last),
        .o_push    (w_push),
        .o_entry   (w_in_entry)
    );

    spca_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_entry (w_out_entry)
    );

    spca_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_entry      (w_out_entry),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_curvature  (o_curvature),
        .o_kept_count (o_kept_count)
    );

endmodule
